@@ rtl/ssc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort unit package
// Control word layout, step codes and the microcode table shared by the
// sequencer and the datapath of the selection sort unit.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int MAX_ITEMS_DEF = 64;

	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 6;
	localparam int COMPARE_W  = 11;
	localparam int SWAP_W     = 6;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Register word index of the sort direction register.
	localparam logic REG_SORT_DESCENDING = 1'b0;

	// Step codes of the control program.
	typedef logic [3:0] step_t;
	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_OUTER  = 4'd1;
	localparam step_t ST_FIRST  = 4'd2;
	localparam step_t ST_SCAN   = 4'd3;
	localparam step_t ST_SWAP_A = 4'd4;
	localparam step_t ST_SWAP_B = 4'd5;
	localparam step_t ST_EMIT0  = 4'd6;
	localparam step_t ST_EMIT   = 4'd7;
	localparam step_t ST_FIN    = 4'd8;

	// Source of the memory read address.
	typedef enum logic [1:0] {
		RD_I     = 2'd0,
		RD_J     = 2'd1,
		RD_ZERO  = 2'd2,
		RD_INEXT = 2'd3
	} rd_sel_t;

	// Branch condition. A true condition loads the target, a false one
	// falls through to the next step; the launch condition holds instead.
	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_GOTO      = 3'd1,
		C_LAUNCH    = 3'd2,
		C_I_LAST    = 3'd3,
		C_SCAN_MORE = 3'd4,
		C_EMIT_MORE = 3'd5
	} cond_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    set_j;
		logic    first;
		logic    scan;
		logic    wr_i;
		logic    wr_pick;
		logic    inc_i;
		logic    clr_i;
		logic    emit;
		logic    finish;
		cond_t   cond;
		step_t   target;
	} cw_t;

	// Status flags the datapath hands to the sequencer.
	typedef struct packed {
		logic launch;
		logic i_last;
		logic scan_more;
		logic emit_more;
	} status_t;

	function automatic cw_t ucode(input step_t step);
		cw_t cw;
		cw = '{rd_sel: RD_I, cond: C_NEXT, target: ST_IDLE, default: 1'b0};
		unique case (step)
			ST_IDLE: begin
				cw.cond   = C_LAUNCH;
				cw.target = ST_OUTER;
			end
			ST_OUTER: begin
				cw.rd_sel = RD_I;
				cw.set_j  = 1'b1;
				cw.cond   = C_I_LAST;
				cw.target = ST_EMIT0;
			end
			ST_FIRST: begin
				cw.rd_sel = RD_J;
				cw.first  = 1'b1;
			end
			ST_SCAN: begin
				cw.rd_sel = RD_J;
				cw.scan   = 1'b1;
				cw.cond   = C_SCAN_MORE;
				cw.target = ST_SCAN;
			end
			ST_SWAP_A: begin
				cw.wr_i = 1'b1;
			end
			ST_SWAP_B: begin
				cw.wr_pick = 1'b1;
				cw.inc_i   = 1'b1;
				cw.cond    = C_GOTO;
				cw.target  = ST_OUTER;
			end
			ST_EMIT0: begin
				cw.rd_sel = RD_ZERO;
				cw.clr_i  = 1'b1;
			end
			ST_EMIT: begin
				cw.rd_sel = RD_INEXT;
				cw.emit   = 1'b1;
				cw.inc_i  = 1'b1;
				cw.cond   = C_EMIT_MORE;
				cw.target = ST_EMIT;
			end
			ST_FIN: begin
				cw.finish = 1'b1;
				cw.cond   = C_GOTO;
				cw.target = ST_IDLE;
			end
			default: begin
				cw.cond   = C_GOTO;
				cw.target = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ rtl/ssc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort sequencer
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module ssc_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  ssc_pkg::status_t status,
	output ssc_pkg::cw_t     cw,
	output logic             busy
);

	ssc_pkg::step_t step_q;
	ssc_pkg::step_t step_next;
	ssc_pkg::step_t step_inc;

	assign cw       = ssc_pkg::ucode(step_q);
	assign busy     = (step_q != ssc_pkg::ST_IDLE);
	assign step_inc = step_q + ssc_pkg::step_t'(1);

	always_comb begin
		step_next = step_inc;
		unique case (cw.cond)
			ssc_pkg::C_NEXT:      step_next = step_inc;
			ssc_pkg::C_GOTO:      step_next = cw.target;
			ssc_pkg::C_LAUNCH:    step_next = status.launch ? cw.target : step_q;
			ssc_pkg::C_I_LAST:    step_next = status.i_last ? cw.target : step_inc;
			ssc_pkg::C_SCAN_MORE: step_next = status.scan_more ? cw.target : step_inc;
			ssc_pkg::C_EMIT_MORE: step_next = status.emit_more ? cw.target : step_inc;
			default:              step_next = ssc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ssc_pkg::ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

@@ rtl/selection_sort_counting_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort unit with comparison and swap counts
// Loads a list of signed words, sorts it in place by selection sort and
// streams the sorted list out with the run's comparison and swap totals.
// ----------------------------------------------------------------------------
// A list is loaded one element per beat: an element is taken at each clock
// edge with start high and busy low, so loading runs at one element per
// cycle with busy staying low. The beat with is_final high ends the list and
// raises busy until the whole sorted list has been sent. The results leave
// as a burst of n beats, one per cycle, each marked by result_valid for a
// single cycle; the receiver cannot stall them and must take every beat.
// After the final beat of a list busy stays high while the list is sorted
// and sent, so the next list can start its first beat once busy is low
// again. The element memory, with one write and one read port, serves one
// comparison per cycle in the scan loop. For each of the first n-1 positions
// the element is read and the scan primed, then a swap is written in two
// halves. The output burst reads the memory once per beat. Closing steps
// check the last position and prime the first read of the burst, and the
// sequencer returns to idle after the burst. Items arriving when the list
// already holds MAX_ITEMS elements are dropped and flagged on overflowed.
// The sort direction register at byte address 0 selects ascending (0) or
// descending (1) order and is meant to be written only while busy is low.
// ----------------------------------------------------------------------------
module selection_sort_counting_unit #(
	parameter int MAX_ITEMS = ssc_pkg::MAX_ITEMS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// command side
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [ssc_pkg::VALUE_W-1:0]     item_value,
	input  logic                                   is_final,
	// result side
	output logic                                   result_valid,
	output logic signed [ssc_pkg::VALUE_W-1:0]     sorted_value,
	output logic        [ssc_pkg::POSITION_W-1:0]  position,
	output logic                                   run_end,
	output logic        [ssc_pkg::COMPARE_W-1:0]   compare_total,
	output logic        [ssc_pkg::SWAP_W-1:0]      swap_total,
	output logic                                   overflowed,
	// register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [ssc_pkg::ADDR_W-1:0]      paddr,
	input  logic        [ssc_pkg::DATA_W-1:0]      pwdata,
	output logic        [ssc_pkg::DATA_W-1:0]      prdata,
	output logic                                   pready
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	// Element memory: one write and one registered read per cycle.
	logic [ssc_pkg::VALUE_W-1:0] mem [MAX_ITEMS];
	logic [ssc_pkg::VALUE_W-1:0] rd_q;
	logic [AW-1:0]               rd_addr;
	logic                        mem_we;
	logic [AW-1:0]               mem_wa;
	logic [ssc_pkg::VALUE_W-1:0] mem_wd;

	// Control state.
	logic [CW-1:0]                cnt_q;
	logic                         drop_q;
	logic                         desc_q;
	logic [ssc_pkg::COMPARE_W-1:0] cmp_q;
	logic [ssc_pkg::SWAP_W-1:0]   swp_q;

	// Sort working registers.
	logic [AW-1:0]               i_q;
	logic [AW-1:0]               j_q;
	logic [AW-1:0]               cidx_q;
	logic [AW-1:0]               pick_q;
	logic [AW-1:0]               last_q;
	logic [ssc_pkg::VALUE_W-1:0] best_q;
	logic [ssc_pkg::VALUE_W-1:0] ival_q;

	ssc_pkg::cw_t     cw;
	ssc_pkg::status_t status;

	logic accept;
	logic has_room;
	logic swap_needed;
	logic precedes;
	logic cfg_wr;

	ssc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw),
		.busy   (busy)
	);

	assign accept      = start && !busy;
	assign has_room    = (cnt_q < CW'(MAX_ITEMS));
	assign swap_needed = (pick_q != i_q);

	assign status.launch    = accept && is_final;
	assign status.i_last    = (i_q == last_q);
	assign status.scan_more = (cidx_q != last_q);
	assign status.emit_more = (i_q != last_q);

	// The candidate from memory wins only when strictly ahead of the
	// current best, so the first of equal elements is kept.
	assign precedes = desc_q ? ($signed(rd_q) > $signed(best_q))
	                         : ($signed(rd_q) < $signed(best_q));

	always_comb begin
		case (cw.rd_sel)
			ssc_pkg::RD_I:     rd_addr = i_q;
			ssc_pkg::RD_J:     rd_addr = j_q;
			ssc_pkg::RD_ZERO:  rd_addr = '0;
			ssc_pkg::RD_INEXT: rd_addr = i_q + AW'(1);
			default:           rd_addr = i_q;
		endcase
	end

	// Write port: loading while idle, then the two halves of a swap.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[AW-1:0];
		mem_wd = item_value;
		if (accept && has_room) begin
			mem_we = 1'b1;
		end else if (cw.wr_i && swap_needed) begin
			mem_we = 1'b1;
			mem_wa = i_q;
			mem_wd = best_q;
		end else if (cw.wr_pick && swap_needed) begin
			mem_we = 1'b1;
			mem_wa = pick_q;
			mem_wd = ival_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	// Counters, flags and the direction register.
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			desc_q <= 1'b0;
			cmp_q  <= '0;
			swp_q  <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == ssc_pkg::REG_SORT_DESCENDING)) begin
				desc_q <= pwdata[0];
			end
			if (accept) begin
				if (has_room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cw.scan) begin
				cmp_q <= cmp_q + ssc_pkg::COMPARE_W'(1);
			end
			if (cw.wr_i && swap_needed) begin
				swp_q <= swp_q + ssc_pkg::SWAP_W'(1);
			end
			if (cw.finish) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
				cmp_q  <= '0;
				swp_q  <= '0;
			end
		end
	end

	// Sort datapath driven by the control word.
	always_ff @(posedge clk) begin
		if (status.launch) begin
			i_q    <= '0;
			last_q <= has_room ? cnt_q[AW-1:0] : AW'(MAX_ITEMS - 1);
		end
		if (cw.set_j) begin
			j_q <= i_q + AW'(1);
		end
		if (cw.first) begin
			best_q <= rd_q;
			ival_q <= rd_q;
			pick_q <= i_q;
			cidx_q <= j_q;
			j_q    <= j_q + AW'(1);
		end
		if (cw.scan) begin
			if (precedes) begin
				best_q <= rd_q;
				pick_q <= cidx_q;
			end
			cidx_q <= j_q;
			j_q    <= j_q + AW'(1);
		end
		if (cw.inc_i) begin
			i_q <= i_q + AW'(1);
		end
		if (cw.clr_i) begin
			i_q <= '0;
		end
	end

	// Result beat: the memory word read in the previous step.
	assign result_valid  = cw.emit;
	assign sorted_value  = rd_q;
	assign position      = ssc_pkg::POSITION_W'(i_q);
	assign run_end       = status.i_last;
	assign compare_total = cmp_q;
	assign swap_total    = swp_q;
	assign overflowed    = drop_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ssc_pkg::REG_SORT_DESCENDING)
	              ? {{(ssc_pkg::DATA_W-1){1'b0}}, desc_q}
	              : '0;

endmodule
